@@ design/mipsc_pkg.sv @@
// Package for the integer core: opcodes, result kinds, fault codes and the
// front-to-back command record. No dependencies.
package mipsc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] BootVector = 32'hBFC00000;
  localparam logic [31:0] ExcVector  = 32'h80000080;

  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNIMP = 2'd1;
  localparam logic [1:0] FAULT_BREAK = 2'd2;
  localparam logic [1:0] FAULT_INPUT = 2'd3;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Primary opcodes used by name.
  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07;
  localparam logic [5:0] OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_SLTI = 6'h0A, OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI = 6'h0C, OP_ORI = 6'h0D, OP_XORI = 6'h0E, OP_LUI = 6'h0F;
  localparam logic [5:0] OP_COP0 = 6'h10, OP_COP2 = 6'h12;
  localparam logic [5:0] OP_LB = 6'h20, OP_LH = 6'h21, OP_LWL = 6'h22, OP_LW = 6'h23;
  localparam logic [5:0] OP_LBU = 6'h24, OP_LHU = 6'h25, OP_LWR = 6'h26;
  localparam logic [5:0] OP_SB = 6'h28, OP_SH = 6'h29, OP_SWL = 6'h2A, OP_SW = 6'h2B;
  localparam logic [5:0] OP_SWR = 6'h2E, OP_LWC0 = 6'h30, OP_SWC0 = 6'h38;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C, FN_BREAK = 6'h0D, FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11, FN_MFLO = 6'h12, FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV = 6'h1A, FN_DIVU = 6'h1B;
  localparam logic [5:0] FN_ADD = 6'h20, FN_ADDU = 6'h21, FN_SUB = 6'h22, FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24, FN_OR = 6'h25, FN_XOR = 6'h26, FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A, FN_SLTU = 6'h2B;

  // One accepted input item as the front hands it to the back.
  typedef struct packed {
    logic        func;
    logic [31:0] instruction;
    logic [31:0] read_data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_OUT1, ST_OUT2
  } back_state_t;

endpackage

@@ design/mipsc_front.sv @@
// Front of the core: takes input transfers and queues them for the back end.
// Depends on mipsc_pkg.
module mipsc_front #(
  parameter int unsigned DEPTH = mipsc_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mipsc_pkg::cmd_t in_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output mipsc_pkg::cmd_t q_cmd
);
  import mipsc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            slots [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     count;
  logic            push, pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = slots[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_cmd;
  end

endmodule

@@ design/mipsc_back.sv @@
// Back end of the core: architectural state, execution, multiply and divide
// units and the result register. Depends on mipsc_pkg.
module mipsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  mipsc_pkg::cmd_t q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      kind,
  output logic [31:0]     address,
  output logic [1:0]      size,
  output logic [31:0]     write_data,
  output logic            last,
  output logic [1:0]      fault
);
  import mipsc_pkg::*;

  logic [31:0] gpr [32];
  logic [31:0] cop0 [32];
  logic [31:0] hi, lo, cur_pc, nxt_pc, aft_pc;
  logic [4:0]  pl_reg0, pl_reg1;
  logic [31:0] pl_val0, pl_val1;
  logic        waiting;
  logic [31:0] held_instr, held_addr;

  back_state_t state, state_next;

  // Pending results: first (optional write) and second (final).
  logic [1:0]  r1_kind, r2_kind, r2_size, r2_fault;
  logic [31:0] r1_addr, r1_data, r2_addr;
  logic [1:0]  r1_size;

  // Multiply / divide unit.
  logic [63:0] mul_acc;
  logic [31:0] mul_b;
  logic [31:0] md_a;
  logic [5:0]  md_cnt;
  logic [31:0] div_q, div_r, div_d;
  logic        md_neg_q, md_neg_r, md_signed;

  logic [31:0] w, rd, a, b, sx16, ea;
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rdx, sa;
  assign w   = q_cmd.instruction;
  assign rd  = q_cmd.read_data;
  assign op  = w[31:26];
  assign fn  = w[5:0];
  assign rs  = w[25:21];
  assign rt  = w[20:16];
  assign rdx = w[15:11];
  assign sa  = w[10:6];
  assign a   = gpr[rs];
  assign b   = gpr[rt];
  assign sx16 = {{16{w[15]}}, w[15:0]};
  assign ea  = a + sx16;

  assign q_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT1) || (state == ST_OUT2);
  always_comb begin
    if (state == ST_OUT1) begin
      kind = r1_kind; address = r1_addr; size = r1_size; write_data = r1_data;
      last = 1'b0; fault = FAULT_NONE;
    end else begin
      kind = r2_kind; address = r2_addr; size = r2_size; write_data = '0;
      last = 1'b1; fault = r2_fault;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_OUT1: if (out_ready) state_next = ST_OUT2;
      ST_OUT2: if (out_ready) state_next = ST_IDLE;
      ST_MUL:  if (md_cnt == 6'd31) state_next = ST_OUT2;
      ST_DIV:  if (md_cnt == 6'd31) state_next = ST_FIX;
      ST_FIX:  state_next = ST_OUT2;
      default: state_next = state;
    endcase
  end

  function automatic logic [1:0] rsize(input logic [5:0] o);
    logic [1:0] s;
    if (o == OP_LB || o == OP_LBU) s = SZ_BYTE;
    else if (o == OP_LH || o == OP_LHU) s = SZ_HALF;
    else s = SZ_WORD;
    return s;
  endfunction

  function automatic logic [31:0] raddr(input logic [5:0] o, input logic [31:0] ad);
    if (o == OP_LWL || o == OP_LWR || o == OP_SWL || o == OP_SWR) return {ad[31:2], 2'b00};
    return ad;
  endfunction

  // Execution of one queued item; all state updates in one clocked block.
  always_ff @(posedge clk) begin
    logic [31:0] g [32];
    logic [31:0] c0 [32];
    logic [31:0] npc, apc, cpc, hnew, lnew, v, old, m;
    logic [4:0]  p0r, p1r;
    logic [31:0] p0v, p1v;
    logic [1:0]  flt;
    logic        has_w, go_md, fin;
    logic [4:0]  dst;
    logic        dwr;
    if (rst) begin
      for (int i = 0; i < 32; i++) begin gpr[i] <= '0; cop0[i] <= '0; end
      hi <= '0; lo <= '0;
      cur_pc <= BootVector; nxt_pc <= BootVector + 32'd4; aft_pc <= BootVector + 32'd8;
      pl_reg0 <= '0; pl_reg1 <= '0; pl_val0 <= '0; pl_val1 <= '0;
      waiting <= 1'b0;
      state <= ST_IDLE;
    end else begin
      if (state != ST_IDLE) state <= state_next;
      if (state == ST_MUL) begin
        mul_acc <= {1'b0, mul_acc[63:1]} + (mul_acc[0] ? {1'b0, mul_b, 31'd0} : 64'd0);
        md_cnt  <= md_cnt + 6'd1;
        if (md_cnt == 6'd31) begin
          v = mul_acc[0] ? (mul_acc[63:32] + mul_b) : mul_acc[63:32];
          hnew = {1'b0, v[31:1]} | {(mul_acc[0] && (mul_acc[63:32] + mul_b < mul_b)), 31'd0};
          lnew = {v[0], mul_acc[31:1]};
          if (md_signed) begin
            // Signed correction: subtract the sign-weighted operands.
            hnew = hnew - (md_neg_q ? mul_b : 32'd0) - (md_neg_r ? md_a : 32'd0);
          end
          hi <= hnew; lo <= lnew;
        end
      end
      if (state == ST_DIV) begin
        v = {div_r[30:0], div_q[31]};
        if ({div_r[31], v} >= {1'b0, div_d}) begin
          div_r <= v - div_d; div_q <= {div_q[30:0], 1'b1};
        end else begin
          div_r <= v; div_q <= {div_q[30:0], 1'b0};
        end
        md_cnt <= md_cnt + 6'd1;
      end
      if (state == ST_FIX) begin
        lo <= md_neg_q ? -div_q : div_q;
        hi <= md_neg_r ? -div_r : div_r;
      end
      if (state == ST_IDLE && q_valid) begin
        for (int i = 0; i < 32; i++) begin g[i] = gpr[i]; c0[i] = cop0[i]; end
        npc = nxt_pc; apc = aft_pc; cpc = cur_pc;
        p0r = pl_reg0; p0v = pl_val0; p1r = pl_reg1; p1v = pl_val1;
        hnew = hi; lnew = lo;
        flt = FAULT_NONE; has_w = 1'b0; go_md = 1'b0; fin = 1'b1;
        dst = '0; dwr = 1'b0; v = '0; m = '0; old = '0;
        r1_kind <= KIND_WRITE;
        if (waiting) begin
          fin = q_cmd.func;
          if (!q_cmd.func) begin
            r2_kind <= KIND_READ;
            r2_addr <= raddr(held_instr[31:26], held_addr);
            r2_size <= rsize(held_instr[31:26]);
            r2_fault <= FAULT_INPUT;
          end else begin
            waiting <= 1'b0;
            dst = held_instr[20:16];
            old = (p0r == dst) ? p0v : g[dst];
            case (held_instr[31:26])
              OP_LB:  v = {{24{rd[7]}}, rd[7:0]};
              OP_LH:  v = {{16{rd[15]}}, rd[15:0]};
              OP_LW:  v = rd;
              OP_LBU: v = {24'd0, rd[7:0]};
              OP_LHU: v = {16'd0, rd[15:0]};
              OP_LWL: case (held_addr[1:0])
                  2'd0: v = {rd[7:0], old[23:0]};
                  2'd1: v = {rd[15:0], old[15:0]};
                  2'd2: v = {rd[23:0], old[7:0]};
                  default: v = rd;
                endcase
              OP_LWR: case (held_addr[1:0])
                  2'd0: v = rd;
                  2'd1: v = {old[31:24], rd[31:8]};
                  2'd2: v = {old[31:16], rd[31:16]};
                  default: v = {old[31:8], rd[31:24]};
                endcase
              OP_SWL: begin
                has_w = 1'b1;
                case (held_addr[1:0])
                  2'd0: m = {rd[31:8], g[dst][31:24]};
                  2'd1: m = {rd[31:16], g[dst][31:16]};
                  2'd2: m = {rd[31:24], g[dst][31:8]};
                  default: m = g[dst];
                endcase
              end
              OP_SWR: begin
                has_w = 1'b1;
                case (held_addr[1:0])
                  2'd0: m = g[dst];
                  2'd1: m = {g[dst][23:0], rd[7:0]};
                  2'd2: m = {g[dst][15:0], rd[15:0]};
                  default: m = {g[dst][7:0], rd[23:0]};
                endcase
              end
              default: c0[dst] = rd;
            endcase
            if (held_instr[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWL, OP_LWR})
            begin
              p1r = dst; p1v = v;
              if (dst == p0r) begin p0r = '0; p0v = '0; end
            end
            r1_addr <= {held_addr[31:2], 2'b00}; r1_data <= m; r1_size <= SZ_WORD;
          end
        end else if (q_cmd.func) begin
          fin = 1'b0;
          r2_kind <= KIND_FETCH; r2_addr <= {cur_pc[31:2], 2'b00};
          r2_size <= SZ_WORD; r2_fault <= FAULT_INPUT;
        end else if (op inside {[OP_LB:OP_LWR], OP_SWL, OP_SWR, OP_LWC0}) begin
          fin = 1'b0;
          waiting <= 1'b1; held_instr <= w; held_addr <= ea;
          r2_kind <= KIND_READ; r2_addr <= raddr(op, ea);
          r2_size <= rsize(op); r2_fault <= FAULT_NONE;
        end else if (op == OP_SB || op == OP_SH || op == OP_SW || op == OP_SWC0) begin
          has_w = 1'b1;
          v = (op == OP_SWC0) ? c0[rt] : b;
          r1_addr <= ea;
          if (op == OP_SB) begin r1_size <= SZ_BYTE; r1_data <= {24'd0, v[7:0]}; end
          else if (op == OP_SH) begin r1_size <= SZ_HALF; r1_data <= {16'd0, v[15:0]}; end
          else begin r1_size <= SZ_WORD; r1_data <= v; end
        end else begin
          case (op)
            OP_SPECIAL: case (fn)
                FN_SLL:  begin dst = rdx; dwr = 1'b1; v = b << sa; end
                FN_SRL:  begin dst = rdx; dwr = 1'b1; v = b >> sa; end
                FN_SRA:  begin dst = rdx; dwr = 1'b1; v = $signed(b) >>> sa; end
                FN_SLLV: begin dst = rdx; dwr = 1'b1; v = b << a[4:0]; end
                FN_SRLV: begin dst = rdx; dwr = 1'b1; v = b >> a[4:0]; end
                FN_SRAV: begin dst = rdx; dwr = 1'b1; v = $signed(b) >>> a[4:0]; end
                FN_JR:   apc = a;
                FN_JALR: begin dst = rdx; dwr = 1'b1; v = apc; apc = a; end
                FN_SYSCALL: begin
                  c0[13] = {c0[13][31:8], 8'd32};
                  c0[12] = {c0[12][31:8], 2'b00, c0[12][3:0], 2'b00};
                  c0[14] = cpc;
                  npc = ExcVector; apc = ExcVector + 32'd4;
                end
                FN_BREAK: flt = FAULT_BREAK;
                FN_MFHI: begin dst = rdx; dwr = 1'b1; v = hi; end
                FN_MTHI: hnew = a;
                FN_MFLO: begin dst = rdx; dwr = 1'b1; v = lo; end
                FN_MTLO: lnew = a;
                FN_MULT, FN_MULTU: begin
                  go_md = 1'b1;
                  md_signed <= (fn == FN_MULT);
                  md_neg_q <= (fn == FN_MULT) && a[31];
                  md_neg_r <= (fn == FN_MULT) && b[31];
                  md_a <= a; mul_b <= b; mul_acc <= {32'd0, a}; md_cnt <= '0;
                end
                FN_DIV, FN_DIVU: begin
                  if (b == '0) begin
                    hnew = a;
                    lnew = (fn == FN_DIV && a[31]) ? 32'd1 : 32'hFFFFFFFF;
                  end else if (fn == FN_DIV && b == 32'hFFFFFFFF && a == 32'h80000000) begin
                    hnew = '0; lnew = 32'h80000000;
                  end else begin
                    go_md = 1'b1;
                    md_neg_q <= (fn == FN_DIV) && (a[31] ^ b[31]);
                    md_neg_r <= (fn == FN_DIV) && a[31];
                    div_q <= (fn == FN_DIV && a[31]) ? -a : a;
                    div_d <= (fn == FN_DIV && b[31]) ? -b : b;
                    div_r <= '0; md_cnt <= '0;
                  end
                end
                FN_ADD, FN_ADDU: begin dst = rdx; dwr = 1'b1; v = a + b; end
                FN_SUB, FN_SUBU: begin dst = rdx; dwr = 1'b1; v = a - b; end
                FN_AND: begin dst = rdx; dwr = 1'b1; v = a & b; end
                FN_OR:  begin dst = rdx; dwr = 1'b1; v = a | b; end
                FN_XOR: begin dst = rdx; dwr = 1'b1; v = a ^ b; end
                FN_NOR: begin dst = rdx; dwr = 1'b1; v = ~(a | b); end
                FN_SLT: begin dst = rdx; dwr = 1'b1; v = {31'd0, $signed(a) < $signed(b)}; end
                FN_SLTU: begin dst = rdx; dwr = 1'b1; v = {31'd0, a < b}; end
                default: flt = FAULT_UNIMP;
              endcase
            OP_REGIMM: begin
              v = apc;
              if (rt[0] != a[31]) apc = npc + {sx16[29:0], 2'b00};
              if (rt[4:1] == 4'b1000) begin dst = 5'd31; dwr = 1'b1; end
            end
            OP_J:   apc = {npc[31:28], w[25:0], 2'b00};
            OP_JAL: begin
              v = apc; dst = 5'd31; dwr = 1'b1;
              apc = {npc[31:28], w[25:0], 2'b00};
            end
            OP_BEQ:  if (a == b) apc = npc + {sx16[29:0], 2'b00};
            OP_BNE:  if (a != b) apc = npc + {sx16[29:0], 2'b00};
            OP_BLEZ: if (a[31] || a == '0) apc = npc + {sx16[29:0], 2'b00};
            OP_BGTZ: if (!a[31] && a != '0) apc = npc + {sx16[29:0], 2'b00};
            OP_ADDI, OP_ADDIU: begin dst = rt; dwr = 1'b1; v = ea; end
            OP_SLTI:  begin dst = rt; dwr = 1'b1; v = {31'd0, $signed(a) < $signed(sx16)}; end
            OP_SLTIU: begin dst = rt; dwr = 1'b1; v = {31'd0, a < sx16}; end
            OP_ANDI: begin dst = rt; dwr = 1'b1; v = a & {16'd0, w[15:0]}; end
            OP_ORI:  begin dst = rt; dwr = 1'b1; v = a | {16'd0, w[15:0]}; end
            OP_XORI: begin dst = rt; dwr = 1'b1; v = a ^ {16'd0, w[15:0]}; end
            OP_LUI:  begin dst = rt; dwr = 1'b1; v = {w[15:0], 16'd0}; end
            OP_COP0: begin
              if (rs[4]) c0[12] = {c0[12][31:4], c0[12][5:2]};
              else if (rs == 5'd0) g[rt] = c0[rdx];
              else if (rs == 5'd4) begin if (rdx != 5'd13) c0[rdx] = b; end
              else flt = FAULT_UNIMP;
            end
            OP_COP2, 6'h31, 6'h32, 6'h33, 6'h39, 6'h3A, 6'h3B: flt = FAULT_NONE;
            default: flt = FAULT_UNIMP;
          endcase
          if (dwr) begin
            g[dst] = v;
            if (dst == p0r) begin p0r = '0; p0v = '0; end
          end
        end
        if (fin) begin
          cpc = npc; npc = apc; apc = apc + 32'd4;
          g[p0r] = p0v;
          p0r = p1r; p0v = p1v; p1r = '0; p1v = '0;
          g[0] = '0;
          r2_kind <= KIND_FETCH; r2_addr <= {cpc[31:2], 2'b00};
          r2_size <= SZ_WORD; r2_fault <= flt;
        end
        for (int i = 0; i < 32; i++) begin gpr[i] <= g[i]; cop0[i] <= c0[i]; end
        cur_pc <= cpc; nxt_pc <= npc; aft_pc <= apc;
        pl_reg0 <= p0r; pl_val0 <= p0v; pl_reg1 <= p1r; pl_val1 <= p1v;
        hi <= hnew; lo <= lnew;
        if (go_md) state <= (fn == FN_MULT || fn == FN_MULTU) ? ST_MUL : ST_DIV;
        else state <= has_w ? ST_OUT1 : ST_OUT2;
      end
    end
  end

endmodule

@@ design/mips_r3000_integer_core.sv @@
// Top level of the MIPS R3000 integer core: input queue front and execute back.
// Depends on mipsc_pkg, mipsc_front and mipsc_back.
//
// Channel   Dir  Transfer contents
// s_axis    in   tuser=func, tdata={read_data, instruction}
// m_axis    out  tuser={fault, kind}, tlast=last, tdata={write_data, size, address}
//
// An ordinary instruction leaves the queue and executes in the same cycle, and its
// fetch transfer is offered the next cycle; a store first offers its write transfer.
// Multiply and divide iterate one bit a cycle in the shared multiply/divide unit, and
// divide then takes a sign fixup step. Reset is synchronous and returns pc to the
// boot vector with registers cleared. The two-entry input queue keeps taking
// transfers while the back end stalls, until it is full.
module mips_r3000_integer_core #(
  parameter int unsigned QUEUE_DEPTH = mipsc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // instruction, read_data
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // address, size, write_data, zero fill
  output logic [3:0]  m_axis_tuser,   // kind, fault
  output logic        m_axis_tlast
);
  import mipsc_pkg::*;

  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_ready;
  logic [1:0]  kind, size, fault;
  logic [31:0] address, write_data;

  assign in_cmd.func        = s_axis_tuser;
  assign in_cmd.instruction = s_axis_tdata[31:0];
  assign in_cmd.read_data   = s_axis_tdata[63:32];

  mipsc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  mipsc_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .kind, .address, .size, .write_data, .last(m_axis_tlast), .fault
  );

  assign m_axis_tdata = {6'd0, write_data, size, address};
  assign m_axis_tuser = {fault, kind};

endmodule
